// ===== rtl/aes_ctr_pkg.sv =====
// Shared constants, types and functions of the AES-128 ECB/CTR engine.
// Depends on nothing; the datapath, controller and top level import it.
package aes_ctr_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;
  localparam int InDataW = 136;
  localparam int OutDataW = 128;
  localparam int NumRkWords = 44;
  localparam int NumRkRows = 11;
  localparam int RkIdxW = 6;

  localparam logic [CfgIdxW-1:0] REG_MODE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_LOW = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_IV_HIGH = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_IV_LOW = 3'd4;

  localparam logic MODE_ECB = 1'b0;
  localparam logic MODE_CTR = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic key_start;   // begin the key schedule
    logic rk_write;    // write expanded word
    logic load_block;  // capture input beat and start state
    logic round;       // apply one cipher round
    logic finish;      // form the result register
    logic out_pop;     // result beat taken
  } aes_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_round;
  } aes_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte mask of the leading n bytes of a 64-bit half, n saturating at 8.
  function automatic logic [63:0] lead_mask(input logic [4:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (n > 5'(b)) m[63-8*b -: 8] = 8'hff;
    end
    lead_mask = m;
  endfunction

endpackage

// ===== rtl/aes_ctr_datapath.sv =====
// Datapath: configuration registers, key schedule, round-key memory, cipher state,
// counter and output register. Uses aes_ctr_pkg; driven by aes_ctr_ctrl.
module aes_ctr_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [aes_ctr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [aes_ctr_pkg::CfgDataW-1:0] cfg_data,
  input  logic [aes_ctr_pkg::InDataW-1:0] in_data,
  input  logic                            in_first,
  input  aes_ctr_pkg::aes_cmd_t           cmd,
  output aes_ctr_pkg::aes_sts_t           sts,
  output logic [aes_ctr_pkg::OutDataW-1:0] out_data
);
  import aes_ctr_pkg::*;

  logic         mode;
  logic [63:0]  key_high, key_low, iv_high, iv_low;
  logic [127:0] ctr;

  // Key schedule runs one word per cycle; each full row of four words goes
  // into the round-key memory, one 128-bit row per round.
  logic [127:0]       rk_mem [NumRkRows];
  logic [RkIdxW-1:0]  ks_idx;
  logic [127:0]       ks_win;  // last four words, oldest in top
  logic [7:0]         rcon;
  logic [31:0]        ks_t, ks_new;

  always_comb begin
    ks_t = ks_win[31:0];
    if (ks_idx[1:0] == 2'd0) begin
      ks_t = {SBOX[ks_t[23:16]], SBOX[ks_t[15:8]], SBOX[ks_t[7:0]], SBOX[ks_t[31:24]]}
             ^ {rcon, 24'h0};
    end
    ks_new = ks_win[127:96] ^ ks_t;
  end

  // Configuration and key schedule registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_CTR;
      key_high <= '0;
      key_low <= '0;
      iv_high <= '0;
      iv_low <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:     mode <= cfg_data[0];
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low <= cfg_data;
        REG_IV_HIGH:  iv_high <= cfg_data;
        REG_IV_LOW:   iv_low <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_start) begin
      ks_win <= {key_high, key_low};
      ks_idx <= RkIdxW'(4);
      rcon <= 8'h01;
      rk_mem[0] <= {key_high, key_low};
    end else if (cmd.rk_write) begin
      if (ks_idx[1:0] == 2'd3) rk_mem[ks_idx[5:2]] <= {ks_win[95:0], ks_new};
      ks_win <= {ks_win[95:0], ks_new};
      ks_idx <= ks_idx + 1'b1;
      if (ks_idx[1:0] == 2'd0) rcon <= xtime(rcon);
    end
  end

  // Cipher state: one round per cycle, round key read as one registered row
  // that is fetched in the cycle before the round that uses it.
  logic [127:0] st;
  logic [3:0]   rnd;
  logic [127:0] rk_row;
  logic         blk_mode;
  logic [127:0] blk_data;
  logic [4:0]   blk_n;
  logic [127:0] ctr_use;
  logic [127:0] rnd_out;
  logic [3:0]   rd_round;

  assign ctr_use = in_first ? {iv_high, iv_low} : ctr;
  assign rd_round = cmd.load_block ? 4'd1 : ((rnd < 4'd9) ? rnd + 4'd2 : 4'd10);

  always_ff @(posedge clk) begin
    rk_row <= rk_mem[rd_round];
  end

  always_comb begin
    logic [7:0] a [16];
    logic [7:0] s [16];
    logic [7:0] b0, b1, b2, b3;
    for (int k = 0; k < 16; k++) s[k] = st[127-8*k -: 8];
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++)
        a[c*4+k] = SBOX[s[((c+k)%4)*4+k]];
    for (int c = 0; c < 4; c++) begin
      b0 = a[c*4]; b1 = a[c*4+1]; b2 = a[c*4+2]; b3 = a[c*4+3];
      if (rnd != 4'd9) begin
        s[c*4]   = xtime(b0) ^ xtime(b1) ^ b1 ^ b2 ^ b3;
        s[c*4+1] = b0 ^ xtime(b1) ^ xtime(b2) ^ b2 ^ b3;
        s[c*4+2] = b0 ^ b1 ^ xtime(b2) ^ xtime(b3) ^ b3;
        s[c*4+3] = xtime(b0) ^ b0 ^ b1 ^ b2 ^ xtime(b3);
      end else begin
        s[c*4] = b0; s[c*4+1] = b1; s[c*4+2] = b2; s[c*4+3] = b3;
      end
    end
    for (int k = 0; k < 16; k++) rnd_out[127-8*k -: 8] = s[k];
    rnd_out = rnd_out ^ rk_row;
  end

  assign sts.last_round = (rnd == 4'd9);

  // Block capture, rounds, counter update and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctr <= '0;
    end else if (cmd.load_block && mode == MODE_CTR) begin
      ctr <= ctr_use + 128'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_block) begin
      blk_mode <= mode;
      blk_data <= in_data[127:0];
      blk_n <= in_data[132:128];
      rnd <= '0;
      st <= ((mode == MODE_CTR) ? ctr_use : in_data[127:0]) ^ rk_mem[0];
    end else if (cmd.round) begin
      st <= rnd_out;
      rnd <= rnd + 4'd1;
    end
    if (cmd.finish) begin
      if (blk_mode == MODE_CTR) begin
        out_data <= (blk_data ^ st)
                    & {lead_mask(blk_n), (blk_n > 5'd8) ? lead_mask(blk_n - 5'd8) : 64'h0};
      end else begin
        out_data <= st;
      end
    end
  end

endmodule

// ===== rtl/aes_ctr_ctrl.sv =====
// Controller state machine: key expansion sequencing, round sequencing and handshakes.
// Uses aes_ctr_pkg; commands aes_ctr_datapath.
module aes_ctr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [aes_ctr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  aes_ctr_pkg::aes_sts_t sts,
  output aes_ctr_pkg::aes_cmd_t cmd
);
  import aes_ctr_pkg::*;

  localparam logic [1:0] ST_KSTART = 2'd0;
  localparam logic [1:0] ST_KEXP = 2'd1;
  localparam logic [1:0] ST_IDLE = 2'd2;
  localparam logic [1:0] ST_RUN = 2'd3;

  logic [1:0] state, state_next;
  logic [5:0] kcnt;
  logic       pend;  // result waits for the finish cycle
  logic       key_wr;

  assign key_wr = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
  assign s_tready = (state == ST_IDLE) && !key_wr && (!m_tvalid || m_tready);

  always_comb begin
    cmd = '0;
    cmd.key_start = (state == ST_KSTART);
    cmd.rk_write = (state == ST_KEXP);
    cmd.load_block = s_tvalid && s_tready;
    cmd.round = (state == ST_RUN) && !pend;
    cmd.finish = (state == ST_RUN) && pend;
    cmd.out_pop = m_tvalid && m_tready;
    state_next = state;
    unique case (state)
      ST_KSTART: state_next = ST_KEXP;
      ST_KEXP:   if (kcnt == 6'd39) state_next = ST_IDLE;
      ST_IDLE:   if (cmd.load_block) state_next = ST_RUN;
      ST_RUN:    if (pend) state_next = ST_IDLE;
      default:   state_next = ST_KSTART;
    endcase
    if (key_wr) state_next = ST_KSTART;
  end

  // State, key counter, pending flag and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_KSTART;
      kcnt <= '0;
      pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      kcnt <= (state == ST_KEXP) ? kcnt + 6'd1 : 6'd0;
      if (cmd.round && sts.last_round) pend <= 1'b1;
      else if (cmd.finish) pend <= 1'b0;
      if (cmd.finish) m_tvalid <= 1'b1;
      else if (cmd.out_pop) m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== rtl/aes128_ctr_block_cipher_top.sv =====
// AES-128 ECB/CTR engine, one block at a time: the initial key addition is done
// as the beat is accepted, then ten rounds run through the single round unit and
// a finish step forms the result; the next beat is taken only once that result
// has been formed and can be passed on, so blocks never overlap.
// A result that is not taken holds the input off. After reset and after each key
// write the key schedule expands 40 words, during which no beat is taken.
// Uses aes_ctr_pkg, aes_ctr_ctrl and aes_ctr_datapath.
module aes128_ctr_block_cipher_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // data_high, data_low, valid_bytes, zero pad
  input  logic         s_tuser,   // first_block
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // result_high, result_low
);
  import aes_ctr_pkg::*;

  aes_cmd_t cmd;
  aes_sts_t sts;
  logic [127:0] dp_out;
  logic [InDataW-1:0] dp_in;

  // Clear the pad bits; the datapath port below reorders the beat to {valid_bytes, high, low}.
  assign dp_in = {3'b000, s_tdata[132:128], s_tdata[127:64], s_tdata[63:0]};
  assign m_tdata = {dp_out[63:0], dp_out[127:64]};

  aes_ctr_ctrl u_ctrl (
    .clk, .rst, .cfg_we, .cfg_index, .s_tvalid, .s_tready,
    .m_tvalid, .m_tready, .sts, .cmd
  );

  aes_ctr_datapath u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_data({dp_in[135:128], dp_in[63:0], dp_in[127:64]}),
    .in_first(s_tuser), .cmd, .sts, .out_data(dp_out)
  );

endmodule

// ===== rtl/aes_ctr_checker.sv =====
// Port-level checker of the AES-128 engine, bound to the top level.
// Depends only on the top-level ports.
module aes_ctr_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);
  // No result is shown while an accepted beat is still being processed.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !m_tvalid [*11])
    else $error("result appeared too early");
  // No new beat is taken the cycle after one was taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second beat accepted while busy");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");
endmodule

bind aes128_ctr_block_cipher_top aes_ctr_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
